[rtl/msm_pkg.sv]
// ----------------------------------------------------------------------------
// msm_pkg
// Shared types and constants for the multiway sorted merge core.
// ----------------------------------------------------------------------------
package msm_pkg;

  // Request command codes.
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_PULL   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // Result status codes.
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_END  = 2'd2;

  // Configuration register indexes (paddr[2]).
  localparam logic REG_LISTS_IN_USE = 1'b0;
  localparam logic REG_UNION_MODE   = 1'b1;

  // Configuration reset values.
  localparam logic [2:0] LISTS_IN_USE_RST = 3'd4;
  localparam logic       UNION_MODE_RST   = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  // Outcome of the shared compare unit.
  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

[rtl/msm_list_mem.sv]
// ----------------------------------------------------------------------------
// msm_list_mem
// Single-write, single-read storage for all list values, registered read.
// ----------------------------------------------------------------------------
module msm_list_mem #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [31:0]       wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered: available in the cycle after the address.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/msm_head_cmp.sv]
// ----------------------------------------------------------------------------
// msm_head_cmp
// Shared signed compare unit used for both head ranking and repeat checks.
// ----------------------------------------------------------------------------
module msm_head_cmp
  import msm_pkg::*;
(
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output cmp_res_t           res_o
);

  // One signed magnitude compare and one equality test.
  always_comb begin
    res_o.lt = (a_i < b_i);
    res_o.eq = (a_i == b_i);
  end

endmodule

[rtl/multiway_sorted_merge_core.sv]
// ----------------------------------------------------------------------------
// multiway_sorted_merge_core
// K-way merge of up to LISTS ascending lists of signed 32-bit values.
// ----------------------------------------------------------------------------
// Every accepted request produces exactly one result, strobed on done_o;
// the receiver cannot stall, so done_o must be captured when high.
// Append, clear and no-op requests leave busy low, so they may be issued
// back to back. A pull visits the list heads one per cycle through a single
// memory read port and a single compare unit: one pass scans the first n
// heads, where n is the effective lists_in_use, then decides; in union mode
// a pass repeats for each head equal to the last returned value. busy is
// high until the pull's result is strobed. The list memory needs no
// clearing after reset.
// ----------------------------------------------------------------------------
module multiway_sorted_merge_core
  import msm_pkg::*;
#(
  parameter int LISTS      = 4,
  parameter int LIST_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Command channel.
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic [1:0]         list_id_i,
  input  logic signed [31:0] value_i,
  // Result channel.
  output logic               done_o,
  output logic signed [31:0] merged_value_o,
  output logic [1:0]         status_o,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int Total = LISTS * LIST_DEPTH;
  localparam int AW    = $clog2(Total);
  localparam int LW    = $clog2(LISTS);
  localparam int IW    = $clog2(LISTS + 1);
  localparam int PW    = $clog2(LIST_DEPTH + 1);

  // Configuration registers.
  logic [2:0] lists_q;
  logic       union_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lists_q <= LISTS_IN_USE_RST;
      union_q <= UNION_MODE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LISTS_IN_USE) begin
        lists_q <= pwdata[2:0];
      end else begin
        union_q <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_UNION_MODE) ? {31'b0, union_q} : {29'b0, lists_q};

  // Sequencer and list bookkeeping.
  state_e              state_q, state_d;
  logic [PW-1:0]       len_q [LISTS];
  logic [PW-1:0]       len_d [LISTS];
  logic [PW-1:0]       pos_q [LISTS];
  logic [PW-1:0]       pos_d [LISTS];
  logic [IW-1:0]       scan_idx_q, scan_idx_d;
  logic [AW-1:0]       base_q, base_d;
  logic                pend_valid_q, pend_valid_d;
  logic [LW-1:0]       pend_idx_q, pend_idx_d;
  logic [PW-1:0]       pend_pos_q, pend_pos_d;
  logic                found_q, found_d;
  logic [LW-1:0]       best_idx_q, best_idx_d;
  logic [PW-1:0]       best_pos_q, best_pos_d;
  logic signed [31:0]  best_val_q, best_val_d;
  logic signed [31:0]  last_q, last_d;
  logic                any_q, any_d;
  logic                done_q, done_d;
  logic signed [31:0]  mval_q, mval_d;
  logic [1:0]          status_q, status_d;

  // Memory and compare unit hookups.
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [AW-1:0]       mem_raddr;
  logic signed [31:0]  mem_rdata;
  logic signed [31:0]  cmp_a, cmp_b;
  cmp_res_t            cmp_res;

  // Helper decode.
  logic                accept;
  cmd_e                cmd;
  logic [IW-1:0]       n_eff;
  logic                scan_active;
  logic [LW-1:0]       sel_idx;
  logic [PW-1:0]       len_sel, pos_sel;
  logic                id_ok;
  logic                app_ok;

  assign accept = start & ~busy;
  assign busy   = (state_q != ST_IDLE);
  assign cmd    = cmd_e'(cmd_i);

  // Lists beyond LISTS do not exist.
  assign n_eff = (32'(lists_q) > LISTS) ? IW'(LISTS) : IW'(lists_q);
  assign scan_active = (scan_idx_q < n_eff);

  // One shared read index into the per-list counters.
  assign sel_idx = (state_q == ST_IDLE) ? LW'(list_id_i) : scan_idx_q[LW-1:0];
  assign len_sel = len_q[sel_idx];
  assign pos_sel = pos_q[sel_idx];

  assign id_ok  = (32'(list_id_i) < LISTS);
  assign app_ok = id_ok && (len_sel < PW'(LIST_DEPTH));

  assign mem_we    = accept && (cmd == CMD_APPEND) && app_ok;
  assign mem_waddr = AW'(32'(list_id_i) * LIST_DEPTH + 32'(len_sel));
  assign mem_raddr = base_q + AW'(pos_sel);

  // The compare unit ranks heads while scanning and checks repeats after.
  assign cmp_a = (state_q == ST_DECIDE) ? best_val_q : mem_rdata;
  assign cmp_b = (state_q == ST_DECIDE) ? last_q : best_val_q;

  msm_list_mem #(
    .Depth (Total),
    .AddrW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (value_i),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  msm_head_cmp u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  // Next state and datapath control.
  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    pos_d        = pos_q;
    scan_idx_d   = scan_idx_q;
    base_d       = base_q;
    pend_valid_d = 1'b0;
    pend_idx_d   = pend_idx_q;
    pend_pos_d   = pend_pos_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_pos_d   = best_pos_q;
    best_val_d   = best_val_q;
    last_d       = last_q;
    any_d        = any_q;
    done_d       = 1'b0;
    mval_d       = mval_q;
    status_d     = status_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mval_d   = '0;
          status_d = STATUS_OK;
          unique case (cmd)
            CMD_APPEND: begin
              done_d = 1'b1;
              if (app_ok) begin
                len_d[sel_idx] = len_sel + PW'(1);
              end else begin
                status_d = STATUS_FULL;
              end
            end
            CMD_PULL: begin
              state_d    = ST_SCAN;
              scan_idx_d = '0;
              base_d     = '0;
              found_d    = 1'b0;
            end
            CMD_CLEAR: begin
              done_d = 1'b1;
              for (int i = 0; i < LISTS; i++) begin
                len_d[i] = '0;
                pos_d[i] = '0;
              end
              last_d = '0;
              any_d  = 1'b0;
            end
            CMD_NOP: begin
              done_d = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Rank the head read in the previous cycle.
        if (pend_valid_q && (!found_q || cmp_res.lt)) begin
          found_d    = 1'b1;
          best_idx_d = pend_idx_q;
          best_pos_d = pend_pos_q;
          best_val_d = mem_rdata;
        end
        // Issue the next head read; it counts only if that list still holds values.
        if (scan_active) begin
          pend_valid_d = (pos_sel < len_sel);
          pend_idx_d   = scan_idx_q[LW-1:0];
          pend_pos_d   = pos_sel;
          scan_idx_d   = scan_idx_q + IW'(1);
          base_d       = base_q + AW'(LIST_DEPTH);
        end else begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (!found_q) begin
          state_d  = ST_IDLE;
          done_d   = 1'b1;
          mval_d   = '0;
          status_d = STATUS_END;
        end else begin
          // The taken head stays consumed even when skipped.
          pos_d[best_idx_q] = best_pos_q + PW'(1);
          if (union_q && any_q && cmp_res.eq) begin
            state_d    = ST_SCAN;
            scan_idx_d = '0;
            base_d     = '0;
            found_d    = 1'b0;
          end else begin
            state_d  = ST_IDLE;
            done_d   = 1'b1;
            mval_d   = best_val_q;
            status_d = STATUS_OK;
            last_d   = best_val_q;
            any_d    = 1'b1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      scan_idx_q   <= '0;
      pend_valid_q <= 1'b0;
      found_q      <= 1'b0;
      any_q        <= 1'b0;
      last_q       <= '0;
      done_q       <= 1'b0;
      for (int i = 0; i < LISTS; i++) begin
        len_q[i] <= '0;
        pos_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      scan_idx_q   <= scan_idx_d;
      pend_valid_q <= pend_valid_d;
      found_q      <= found_d;
      any_q        <= any_d;
      last_q       <= last_d;
      done_q       <= done_d;
      len_q        <= len_d;
      pos_q        <= pos_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    base_q     <= base_d;
    pend_idx_q <= pend_idx_d;
    pend_pos_q <= pend_pos_d;
    best_idx_q <= best_idx_d;
    best_pos_q <= best_pos_d;
    best_val_q <= best_val_d;
    mval_q     <= mval_d;
    status_q   <= status_d;
  end

  assign done_o         = done_q;
  assign merged_value_o = mval_q;
  assign status_o       = status_q;

endmodule
